// File: design/cbr_pkg.sv
// Shared types and constants of the CAN broadcast reassembler.
// No dependencies; cbr_buffer, cbr_frame_ctrl and the top level import it.
package cbr_pkg;

  // Command codes of the request channel
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TAKE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ANNOUNCE_ID = 1'b0;
  localparam logic CFG_DATA_ID     = 1'b1;

  // Register reset values and frame constants
  localparam logic [28:0] ANNOUNCE_ID_RESET = 29'h0CECFF25;
  localparam logic [28:0] DATA_ID_RESET     = 29'h0CEBFF25;
  localparam logic [7:0]  ANNOUNCE_CONTROL  = 8'h20;
  localparam logic [3:0]  FULL_DLC          = 4'd8;
  localparam int          BYTES_PER_FRAME   = 7;
  localparam logic [6:0]  TAKE_MAX          = 7'd127;

  // floor(x / 7) == (x * 147) >> 10 for every 7-bit x
  localparam logic [7:0]  DIV7_MUL   = 8'd147;
  localparam int          DIV7_SHIFT = 10;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_RECEIVING = 2'd1,
    PH_COMPLETE  = 2'd2
  } phase_t;

  // One buffer row: the payload of one data frame
  typedef logic [BYTES_PER_FRAME-1:0][7:0] row_bytes_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [28:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
    logic [6:0]  read_index;
  } req_item_t;

  // Result of one beat, less the buffer byte, which comes from the registered read port
  typedef struct packed {
    phase_t     status;
    logic [6:0] taken_length;
    logic       take_ok;
    logic       rd_sel;
    logic [2:0] rd_lane;
  } result_t;

endpackage

// File: design/cbr_if.sv
// Valid/ready channel interfaces of the CAN broadcast reassembler.
// Depends on nothing; used by the top level and its environment.
interface cbr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [28:0] frame_id;
  logic [3:0]  frame_len;
  logic [7:0]  byte_0;
  logic [7:0]  byte_1;
  logic [7:0]  byte_2;
  logic [7:0]  byte_3;
  logic [7:0]  byte_4;
  logic [7:0]  byte_5;
  logic [7:0]  byte_6;
  logic [7:0]  byte_7;
  logic [6:0]  read_index;

  modport source (
    output valid, command, frame_id, frame_len, byte_0, byte_1, byte_2, byte_3,
           byte_4, byte_5, byte_6, byte_7, read_index,
    input  ready
  );
  modport sink (
    input  valid, command, frame_id, frame_len, byte_0, byte_1, byte_2, byte_3,
           byte_4, byte_5, byte_6, byte_7, read_index,
    output ready
  );
endinterface

interface cbr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] rx_status;
  logic [6:0] taken_length;
  logic       take_ok;
  logic [7:0] read_data;

  modport source (
    output valid, rx_status, taken_length, take_ok, read_data,
    input  ready
  );
  modport sink (
    input  valid, rx_status, taken_length, take_ok, read_data,
    output ready
  );
endinterface

// File: design/cbr_buffer.sv
// Message buffer: one row of seven bytes per data frame, row valid bits.
// Depends on cbr_pkg for the row type.
module cbr_buffer #(
  parameter int ROWS  = 12,
  parameter int ROW_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [ROW_W-1:0]    wr_row,
  input  logic [6:0]          wr_mask,
  input  cbr_pkg::row_bytes_t wr_data,
  input  logic                rd_en,
  input  logic [ROW_W-1:0]    rd_row,
  output cbr_pkg::row_bytes_t rd_data
);
  import cbr_pkg::*;

  row_bytes_t       mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  row_bytes_t       mem_q;
  logic             valid_q;

  // Mark rows once written; an unwritten row reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_row] <= 1'b1;
    end
  end

  // Write enabled lanes; the first write of a row zeroes the other lanes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int l = 0; l < BYTES_PER_FRAME; l++) begin
        if (wr_mask[l]) begin
          mem[wr_row][l] <= wr_data[l];
        end else if (!row_valid[wr_row]) begin
          mem[wr_row][l] <= 8'd0;
        end
      end
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q   <= mem[rd_row];
      valid_q <= row_valid[rd_row];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

// File: design/cbr_frame_ctrl.sv
// Frame decoder and reassembly state: phase, length, fill count, ids.
// Depends on cbr_pkg; drives the write and read ports of cbr_buffer.
module cbr_frame_ctrl #(
  parameter int BUFFER_BYTES = 80,
  parameter int ROW_W        = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [28:0]        cfg_data,
  input  logic               accept,
  input  cbr_pkg::req_item_t req,
  output cbr_pkg::result_t   res,
  output logic               wr_en,
  output logic [ROW_W-1:0]   wr_row,
  output logic [6:0]         wr_mask,
  output cbr_pkg::row_bytes_t wr_data,
  output logic               rd_en,
  output logic [ROW_W-1:0]   rd_row
);
  import cbr_pkg::*;

  localparam int              RECV_W  = $clog2(BUFFER_BYTES + 1);
  localparam int              ROWS    = (BUFFER_BYTES + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;
  localparam int              RCNT_W  = $clog2(ROWS + 1);
  localparam logic [15:0]     BUF_LEN = 16'(BUFFER_BYTES);

  logic [28:0]       announce_frame_id;
  logic [28:0]       data_frame_id;
  phase_t            phase;
  phase_t            phase_next;
  logic [15:0]       message_length;
  logic [RECV_W-1:0] received;
  logic [RCNT_W-1:0] recv_row;

  logic              is_frame;
  logic              is_ann;
  logic              is_data;
  logic [15:0]       ann_len;
  logic [10:0]       ann_span;
  logic              ann_fits;
  logic              seq_ok;
  logic              data_go;
  logic [15:0]       recv16;
  logic [15:0]       left;
  logic [15:0]       space;
  logic [2:0]        count_len;
  logic [2:0]        count;
  logic [RECV_W-1:0] recv_sum;
  logic [14:0]       idx_prod;
  logic [4:0]        idx_row;
  logic [7:0]        idx_row7;
  logic [7:0]        idx_lane;
  logic              rd_in_range;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      announce_frame_id <= ANNOUNCE_ID_RESET;
      data_frame_id     <= DATA_ID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANNOUNCE_ID: announce_frame_id <= cfg_data;
        CFG_DATA_ID:     data_frame_id     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Decode the beat
  always_comb begin
    is_frame = (req.command == CMD_FRAME) && (req.frame_len == FULL_DLC);
    is_ann   = is_frame && (req.frame_id == announce_frame_id) &&
               (req.byte_0 == ANNOUNCE_CONTROL);
    is_data  = is_frame && !is_ann && (req.frame_id == data_frame_id);
    ann_len  = {req.byte_2, req.byte_1};
    ann_span = {req.byte_3, 3'b000} - {3'b000, req.byte_3};
    ann_fits = ({1'b0, ann_len} <= 17'(ann_span)) &&
               (({1'b0, ann_len} + 17'd7) > 17'(ann_span)) &&
               (ann_len <= BUF_LEN);
    seq_ok   = (phase == PH_RECEIVING) && ((9'(recv_row) + 9'd1) == {1'b0, req.byte_0});
    data_go  = is_data && seq_ok;
  end

  // Payload byte count: what the message still needs, clipped to the buffer
  always_comb begin
    recv16    = 16'(received);
    left      = (message_length > recv16) ? (message_length - recv16) : 16'd0;
    count_len = (left > 16'd7) ? 3'd7 : left[2:0];
    space     = BUF_LEN - recv16;
    count     = (16'(count_len) > space) ? space[2:0] : count_len;
    recv_sum  = received + RECV_W'(count);
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (req.command)
      CMD_FRAME: begin
        if (is_ann && ann_fits) begin
          phase_next = PH_RECEIVING;
        end else if (data_go && (16'(recv_sum) >= message_length)) begin
          phase_next = PH_COMPLETE;
        end
      end
      CMD_TAKE: begin
        if (phase == PH_COMPLETE) begin
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Split the read index into row and lane
  always_comb begin
    idx_prod    = 15'(req.read_index) * 15'(DIV7_MUL);
    idx_row     = idx_prod[14:DIV7_SHIFT];
    idx_row7    = {idx_row, 3'b000} - {3'b000, idx_row};
    idx_lane    = {1'b0, req.read_index} - idx_row7;
    rd_in_range = 16'(req.read_index) < BUF_LEN;
  end

  // Result and buffer ports
  always_comb begin
    res.status       = phase_next;
    res.take_ok      = (req.command == CMD_TAKE) && (phase == PH_COMPLETE);
    res.taken_length = '0;
    if (res.take_ok) begin
      res.taken_length = (message_length > 16'(TAKE_MAX)) ? TAKE_MAX : message_length[6:0];
    end
    res.rd_sel  = (req.command == CMD_READ) && rd_in_range;
    res.rd_lane = idx_lane[2:0];

    rd_en  = accept && res.rd_sel;
    rd_row = ROW_W'(idx_row);

    wr_en   = accept && data_go && (count != 3'd0);
    wr_row  = ROW_W'(recv_row);
    for (int l = 0; l < BYTES_PER_FRAME; l++) begin
      wr_mask[l] = 3'(l) < count;
    end
    wr_data = {req.byte_7, req.byte_6, req.byte_5, req.byte_4,
               req.byte_3, req.byte_2, req.byte_1};
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      message_length <= '0;
      received       <= '0;
      recv_row       <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (is_ann) begin
        message_length <= ann_len;
      end
      if (is_ann && ann_fits) begin
        received <= '0;
        recv_row <= '0;
      end else if (data_go) begin
        received <= recv_sum;
        if (count == 3'(BYTES_PER_FRAME)) begin
          recv_row <= recv_row + RCNT_W'(1);
        end
      end
    end
  end

  // The fill count never runs past the buffer
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    16'(received) <= BUF_LEN)
    else $error("fill count beyond buffer");

  // The row counter tracks the fill count in whole frames
  a_row_track: assert property (@(posedge clk) disable iff (rst)
    (16'(recv_row) * 16'd7 <= 16'(received)) &&
    (16'(received) < 16'(recv_row) * 16'd7 + 16'd7))
    else $error("row counter out of step with fill count");

  // Buffer writes happen only on beats taken while receiving
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (accept && (phase == PH_RECEIVING)))
    else $error("buffer write outside receiving phase");

  // A successful take leaves the block idle
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && res.take_ok) |=> (phase == PH_IDLE))
    else $error("take did not return to idle");

endmodule

// File: design/can_bam_reassembler_top.sv
// CAN broadcast reassembler top level: channels, result register, buffer.
// Depends on cbr_pkg, cbr_if, cbr_buffer and cbr_frame_ctrl.
//
// Usage: each request beat carries one command: a received CAN frame, a
// take of the completed message, or a read of one buffer byte. Every beat
// yields exactly one response beat with the phase after the command, the
// taken length and flag, and the buffer byte for a read.
// The two frame ids are set on the cfg port (index 0 announce id, index 1
// data id) while no beat is in flight.
// The response is registered: it is valid in the cycle after the request is taken.
// Throughput: one beat per cycle when rsp is not stalled; the frame decode
// and single-row buffer write or read all complete in the accepting cycle.
// Reset: phase idle, length and fill count zero, ids to their defaults;
// the buffer reads as zero through per-row valid bits, with no clearing
// pass, so requests are taken from the first cycle after reset.
// Stall: a response waiting on rsp.ready holds in its register; a new
// request is taken in the same cycle that the waiting response leaves.
module can_bam_reassembler_top #(
  parameter int BUFFER_BYTES = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [28:0]      cfg_data,
  cbr_req_if.sink          req,
  cbr_rsp_if.source        rsp
);
  import cbr_pkg::*;

  localparam int ROWS  = (BUFFER_BYTES + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic             accept;
  req_item_t        req_item;
  result_t          res;
  result_t          res_q;
  logic             rsp_valid;
  logic             wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [6:0]       wr_mask;
  row_bytes_t       wr_data;
  logic             rd_en;
  logic [ROW_W-1:0] rd_row;
  row_bytes_t       rd_data;

  // Take a beat whenever the response register is free or draining
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign req_item = '{
    command:    req.command,
    frame_id:   req.frame_id,
    frame_len:  req.frame_len,
    byte_0:     req.byte_0,
    byte_1:     req.byte_1,
    byte_2:     req.byte_2,
    byte_3:     req.byte_3,
    byte_4:     req.byte_4,
    byte_5:     req.byte_5,
    byte_6:     req.byte_6,
    byte_7:     req.byte_7,
    read_index: req.read_index
  };

  cbr_frame_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .ROW_W        (ROW_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req       (req_item),
    .res       (res),
    .wr_en     (wr_en),
    .wr_row    (wr_row),
    .wr_mask   (wr_mask),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_row    (rd_row)
  );

  cbr_buffer #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_buffer (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_row  (wr_row),
    .wr_mask (wr_mask),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  // Response valid: set on a taken beat, drop once delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Hold the result fields; the buffer read data holds with them
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.rx_status    = res_q.status;
  assign rsp.taken_length = res_q.taken_length;
  assign rsp.take_ok      = res_q.take_ok;
  assign rsp.read_data    = res_q.rd_sel ? rd_data[res_q.rd_lane] : 8'd0;

  // A stalled response must block new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready) |-> !req.ready)
    else $error("request taken over a stalled response");

endmodule
